FILE: hw/rtl/pqph_pkg.sv
// ----------------------------------------------------------------------------
// pqph_pkg
// Shared types and constants of the pyramid quad pattern histogram.
// ----------------------------------------------------------------------------
package pqph_pkg;

  // func codes carried on in_tuser
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int PIX_BITS = 8;
  localparam int IDX_BITS = 9;
  localparam int OUT_BITS = 16;
  localparam int PAT_BITS = 4;

  // bin index layout: whole frame, then 4 quadrants, then 16 sixteenths
  localparam logic [IDX_BITS-1:0] QUAD_BASE = 9'd16;
  localparam logic [IDX_BITS-1:0] SIXT_BASE = 9'd80;
  localparam logic [IDX_BITS-1:0] NUM_BINS  = 9'd336;

  // address widths of the three banks
  localparam int WHOLE_ABITS = 4;
  localparam int QUAD_ABITS  = 6;
  localparam int SIXT_ABITS  = 8;

  localparam int WEIGHT_WHOLE = 1;
  localparam int WEIGHT_QUAD  = 4;
  localparam int WEIGHT_SIXT  = 16;

  localparam logic [PIX_BITS-1:0] THRESH_RESET = 8'd50;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    BANK_WHOLE,
    BANK_QUAD,
    BANK_SIXT
  } bank_sel_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_READ,
    OP_READ_CLEAR
  } bank_op_t;

  // one counted 2x2 window, registered by the window stage
  typedef struct packed {
    logic                hit;
    logic                quad_ok;
    logic                sixt_ok;
    logic [1:0]          quad;
    logic [1:0]          sixt;
    logic [PAT_BITS-1:0] pat;
  } win_t;

endpackage

FILE: hw/rtl/pqph_window.sv
// ----------------------------------------------------------------------------
// pqph_window
// Binarizes pixels, keeps the previous row and forms the 2x2 pattern and
// the region it falls in.
// ----------------------------------------------------------------------------
module pqph_window #(
  parameter int WIDTH  = 48,
  parameter int HEIGHT = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [pqph_pkg::PIX_BITS-1:0] pixel,
  input  logic [pqph_pkg::PIX_BITS-1:0] threshold,
  output pqph_pkg::win_t                win
);

  localparam int CW = $clog2(WIDTH);
  localparam int RW = $clog2(HEIGHT);
  localparam int QW = WIDTH / 2;
  localparam int QH = HEIGHT / 2;
  localparam int SW = QW / 2;
  localparam int SH = QH / 2;

  localparam logic [CW-1:0] COL_LAST = CW'(WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(HEIGHT - 1);
  localparam logic [CW-1:0] QW_V     = CW'(QW);
  localparam logic [CW-1:0] QW_M1    = CW'(QW - 1);
  localparam logic [CW-1:0] QW2_M1   = CW'(2 * QW - 1);
  localparam logic [CW-1:0] SW_V     = CW'(SW);
  localparam logic [CW-1:0] SW_M1    = CW'(SW - 1);
  localparam logic [CW-1:0] SW2_M1   = CW'(2 * SW - 1);
  localparam logic [RW-1:0] QH_V     = RW'(QH);
  localparam logic [RW-1:0] QH_M1    = RW'(QH - 1);
  localparam logic [RW-1:0] QH2_M1   = RW'(2 * QH - 1);
  localparam logic [RW-1:0] SH_V     = RW'(SH);
  localparam logic [RW-1:0] SH_M1    = RW'(SH - 1);
  localparam logic [RW-1:0] SH2_M1   = RW'(2 * SH - 1);

  logic [WIDTH-1:0] line_r;
  logic             left_r;
  logic             above_left_r;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  pqph_pkg::win_t   win_r;
  pqph_pkg::win_t   win_nxt;

  logic          cur;
  logic          above;
  logic [CW-1:0] x;
  logic [CW-1:0] xs;
  logic [RW-1:0] y;
  logic [RW-1:0] ys;
  logic          bx;
  logic          by;

  // the oldest bit of the line shift is the pixel straight above
  assign cur   = pixel > threshold;
  assign above = line_r[WIDTH-1];
  assign x     = col_r - CW'(1);
  assign y     = row_r - RW'(1);
  assign bx    = x >= QW_V;
  assign by    = y >= QH_V;
  assign xs    = bx ? (x - QW_V) : x;
  assign ys    = by ? (y - QH_V) : y;

  always_comb begin
    win_nxt.hit     = push && (col_r != '0) && (row_r != '0);
    win_nxt.quad_ok = (x != QW_M1) && (x < QW2_M1) && (y != QH_M1) && (y < QH2_M1);
    win_nxt.sixt_ok = win_nxt.quad_ok && (xs != SW_M1) && (xs < SW2_M1) &&
                      (ys != SH_M1) && (ys < SH2_M1);
    win_nxt.quad    = {by, bx};
    win_nxt.sixt    = {ys >= SH_V, xs >= SW_V};
    win_nxt.pat     = {above_left_r, above, left_r, cur};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r       <= '0;
      left_r       <= 1'b0;
      above_left_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      win_r        <= '0;
    end else begin
      win_r <= win_nxt;
      if (push) begin
        line_r       <= {line_r[WIDTH-2:0], cur};
        left_r       <= cur;
        above_left_r <= above;
        if (col_r == COL_LAST) begin
          col_r <= '0;
          row_r <= (row_r == ROW_LAST) ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  assign win = win_r;

endmodule

FILE: hw/rtl/pqph_bank.sv
// ----------------------------------------------------------------------------
// pqph_bank
// One bank of histogram bins: registered read, saturating read-modify-write
// in the following cycle, with bypass of the previous write.
// ----------------------------------------------------------------------------
module pqph_bank #(
  parameter int ADDR_BITS  = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pqph_pkg::bank_op_t      op,
  input  logic [ADDR_BITS-1:0]    addr,
  input  logic [COUNT_BITS-1:0]   weight,
  input  logic                    clr_en,
  input  logic [ADDR_BITS-1:0]    clr_addr,
  output logic [COUNT_BITS-1:0]   count
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0] mem_r [DEPTH];
  logic [COUNT_BITS-1:0] rdata_r;
  pqph_pkg::bank_op_t    op_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic                  lw_en_r;
  logic [ADDR_BITS-1:0]  lw_addr_r;
  logic [COUNT_BITS-1:0] lw_data_r;

  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS:0]   sum;
  logic                  we;
  logic [COUNT_BITS-1:0] wdata;

  // take the value written last cycle if it hit the same bin
  assign cur = (lw_en_r && (lw_addr_r == addr_r)) ? lw_data_r : rdata_r;
  assign sum = {1'b0, cur} + {1'b0, weight};

  always_comb begin
    we    = 1'b0;
    wdata = cur;
    case (op_r)
      pqph_pkg::OP_ADD: begin
        we    = 1'b1;
        wdata = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
      pqph_pkg::OP_READ_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
      end
      default: begin
        we    = 1'b0;
        wdata = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= pqph_pkg::OP_NONE;
      lw_en_r <= 1'b0;
    end else begin
      op_r    <= op;
      lw_en_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr;
    rdata_r   <= mem_r[addr];
    lw_addr_r <= addr_r;
    lw_data_r <= wdata;
    if (clr_en) begin
      mem_r[clr_addr] <= '0;
    end else if (we) begin
      mem_r[addr_r] <= wdata;
    end
  end

  assign count = cur;

endmodule

FILE: hw/rtl/pqph_ofifo.sv
// ----------------------------------------------------------------------------
// pqph_ofifo
// Small result queue that decouples the bin pipeline from the output stall.
// ----------------------------------------------------------------------------
module pqph_ofifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [pqph_pkg::OUT_BITS-1:0] push_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pqph_pkg::OUT_BITS-1:0] out_tdata,
  output logic [$clog2(pqph_pkg::FIFO_DEPTH):0] level
);

  localparam int PW = $clog2(pqph_pkg::FIFO_DEPTH);

  logic [pqph_pkg::OUT_BITS-1:0] data_r [pqph_pkg::FIFO_DEPTH];
  logic [PW-1:0]                 wr_ptr_r;
  logic [PW-1:0]                 rd_ptr_r;
  logic [PW:0]                   cnt_r;
  logic                          pop;

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = data_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/pyramid_quad_pattern_histogram.sv
// ----------------------------------------------------------------------------
// pyramid_quad_pattern_histogram
// 2x2 binary pattern histograms over whole frame, quadrants and sixteenths.
// ----------------------------------------------------------------------------
// Takes one beat per clock, pixel pushes and bin reads alike, as long as the
// result side keeps up. A read passes a window/decode register, a registered
// bin-memory read, then a saturating read-modify-write, whose result enters a
// four-entry output queue. Input is held off while the queue plus reads in
// flight could overflow it. The bins live in three memories (16, 64 and 256
// entries); each full 2x2 window updates a whole-frame bin, and a quadrant and
// a sixteenth bin when it lies inside one, with a bypass for back-to-back hits.
// After reset a clearing pass over all 256 addresses zeroes the memories, and
// no input beat is taken until it ends; threshold writes are taken at any time.
module pyramid_quad_pattern_histogram #(
  parameter int WIDTH      = 48,
  parameter int HEIGHT     = 100,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel[7:0], bin_index[16:8], clear_after_read[17], zeros
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // bin_count
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // binarize_threshold
);

  localparam int LW = $clog2(pqph_pkg::FIFO_DEPTH) + 1;
  localparam int CA = pqph_pkg::SIXT_ABITS;

  logic [pqph_pkg::PIX_BITS-1:0] thr_r;
  logic                          clr_done_r;
  logic [CA-1:0]                 clr_cnt_r;

  logic                          accept;
  logic                          push;
  logic [pqph_pkg::PIX_BITS-1:0] pixel;
  logic [pqph_pkg::IDX_BITS-1:0] bin_index;
  logic                          clear_after_read;

  logic                          s1_rd_r;
  logic                          s1_hit_r;
  logic                          s1_clr_r;
  pqph_pkg::bank_sel_t           s1_sel_r;
  logic [CA-1:0]                 s1_addr_r;
  pqph_pkg::bank_sel_t           sel_nxt;
  logic [CA-1:0]                 addr_nxt;

  logic                          s2_rd_r;
  logic                          s2_hit_r;
  pqph_pkg::bank_sel_t           s2_sel_r;

  pqph_pkg::win_t                win;
  pqph_pkg::bank_op_t            rd_op;
  pqph_pkg::bank_op_t            op_whole;
  pqph_pkg::bank_op_t            op_quad;
  pqph_pkg::bank_op_t            op_sixt;
  logic [pqph_pkg::WHOLE_ABITS-1:0] addr_whole;
  logic [pqph_pkg::QUAD_ABITS-1:0]  addr_quad;
  logic [pqph_pkg::SIXT_ABITS-1:0]  addr_sixt;
  logic [COUNT_BITS-1:0]         cnt_whole;
  logic [COUNT_BITS-1:0]         cnt_quad;
  logic [COUNT_BITS-1:0]         cnt_sixt;
  logic [COUNT_BITS-1:0]         cnt_sel;
  logic [pqph_pkg::OUT_BITS-1:0] cnt_sat;
  logic [pqph_pkg::OUT_BITS-1:0] result;
  logic [LW-1:0]                 level;
  logic [LW:0]                   pending;

  assign pixel            = in_tdata[7:0];
  assign bin_index        = in_tdata[16:8];
  assign clear_after_read = in_tdata[17];

  // hold input while the queue could not take every read in flight
  assign pending   = {1'b0, level} + (LW+1)'(s1_rd_r) + (LW+1)'(s2_rd_r);
  assign in_tready = clr_done_r && (pending < (LW+1)'(pqph_pkg::FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (in_tuser == pqph_pkg::FUNC_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= pqph_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + CA'(1);
      if (clr_cnt_r == '1) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  pqph_window #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pixel     (pixel),
    .threshold (thr_r),
    .win       (win)
  );

  // decode the bin index into bank and bank address
  always_comb begin
    if (bin_index < pqph_pkg::QUAD_BASE) begin
      sel_nxt  = pqph_pkg::BANK_WHOLE;
      addr_nxt = CA'(bin_index);
    end else if (bin_index < pqph_pkg::SIXT_BASE) begin
      sel_nxt  = pqph_pkg::BANK_QUAD;
      addr_nxt = CA'(bin_index - pqph_pkg::QUAD_BASE);
    end else begin
      sel_nxt  = pqph_pkg::BANK_SIXT;
      addr_nxt = CA'(bin_index - pqph_pkg::SIXT_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_rd_r <= 1'b0;
      s2_rd_r <= 1'b0;
    end else begin
      s1_rd_r <= accept && (in_tuser == pqph_pkg::FUNC_READ);
      s2_rd_r <= s1_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit_r  <= bin_index < pqph_pkg::NUM_BINS;
    s1_clr_r  <= clear_after_read;
    s1_sel_r  <= sel_nxt;
    s1_addr_r <= addr_nxt;
    s2_hit_r  <= s1_hit_r;
    s2_sel_r  <= s1_sel_r;
  end

  assign rd_op = s1_clr_r ? pqph_pkg::OP_READ_CLEAR : pqph_pkg::OP_READ;

  always_comb begin
    op_whole   = win.hit ? pqph_pkg::OP_ADD : pqph_pkg::OP_NONE;
    op_quad    = (win.hit && win.quad_ok) ? pqph_pkg::OP_ADD : pqph_pkg::OP_NONE;
    op_sixt    = (win.hit && win.sixt_ok) ? pqph_pkg::OP_ADD : pqph_pkg::OP_NONE;
    addr_whole = win.pat;
    addr_quad  = {win.quad, win.pat};
    addr_sixt  = {win.quad, win.sixt, win.pat};
    if (s1_rd_r && s1_hit_r) begin
      case (s1_sel_r)
        pqph_pkg::BANK_WHOLE: begin
          op_whole   = rd_op;
          addr_whole = s1_addr_r[pqph_pkg::WHOLE_ABITS-1:0];
        end
        pqph_pkg::BANK_QUAD: begin
          op_quad    = rd_op;
          addr_quad  = s1_addr_r[pqph_pkg::QUAD_ABITS-1:0];
        end
        pqph_pkg::BANK_SIXT: begin
          op_sixt    = rd_op;
          addr_sixt  = s1_addr_r;
        end
        default: begin
          op_whole   = pqph_pkg::OP_NONE;
        end
      endcase
    end
  end

  pqph_bank #(
    .ADDR_BITS  (pqph_pkg::WHOLE_ABITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bank_whole (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_whole),
    .addr     (addr_whole),
    .weight   (COUNT_BITS'(pqph_pkg::WEIGHT_WHOLE)),
    .clr_en   (!clr_done_r),
    .clr_addr (clr_cnt_r[pqph_pkg::WHOLE_ABITS-1:0]),
    .count    (cnt_whole)
  );

  pqph_bank #(
    .ADDR_BITS  (pqph_pkg::QUAD_ABITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bank_quad (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_quad),
    .addr     (addr_quad),
    .weight   (COUNT_BITS'(pqph_pkg::WEIGHT_QUAD)),
    .clr_en   (!clr_done_r),
    .clr_addr (clr_cnt_r[pqph_pkg::QUAD_ABITS-1:0]),
    .count    (cnt_quad)
  );

  pqph_bank #(
    .ADDR_BITS  (pqph_pkg::SIXT_ABITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bank_sixt (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_sixt),
    .addr     (addr_sixt),
    .weight   (COUNT_BITS'(pqph_pkg::WEIGHT_SIXT)),
    .clr_en   (!clr_done_r),
    .clr_addr (clr_cnt_r),
    .count    (cnt_sixt)
  );

  always_comb begin
    case (s2_sel_r)
      pqph_pkg::BANK_WHOLE: cnt_sel = cnt_whole;
      pqph_pkg::BANK_QUAD:  cnt_sel = cnt_quad;
      pqph_pkg::BANK_SIXT:  cnt_sel = cnt_sixt;
      default:              cnt_sel = '0;
    endcase
  end

  // clamp wide counters to the 16-bit result
  generate
    if (COUNT_BITS > pqph_pkg::OUT_BITS) begin : g_clamp
      assign cnt_sat = (|cnt_sel[COUNT_BITS-1:pqph_pkg::OUT_BITS]) ? '1 :
                       cnt_sel[pqph_pkg::OUT_BITS-1:0];
    end else begin : g_extend
      assign cnt_sat = pqph_pkg::OUT_BITS'(cnt_sel);
    end
  endgenerate

  assign result = s2_hit_r ? cnt_sat : '0;

  pqph_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s2_rd_r),
    .push_data  (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .level      (level)
  );

endmodule

FILE: tb/pqph_bin_checker.sv
// ----------------------------------------------------------------------------
// pqph_bin_checker
// Tracks the pattern histograms from the bus traffic and checks every read.
// ----------------------------------------------------------------------------
// Watches the input, result and threshold ports. It binarizes each accepted
// pixel, forms the 2x2 pattern, and adds it to its own whole-frame, quadrant
// and sixteenth bins. Each accepted read queues the bin value that the block
// must return. Each result beat is compared with the oldest queued value.
// ----------------------------------------------------------------------------
module pqph_bin_checker #(
  parameter int WIDTH      = 48,
  parameter int HEIGHT     = 100,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel[7:0], bin_index[16:8], clear_after_read[17], zeros
  input  logic        in_tuser,   // func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // bin_count
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,  // binarize_threshold
  output int          mismatches,
  output int          reads_outstanding,
  output int          reads_checked,
  output int          saturated_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW   = WIDTH / 2;
  localparam int QH   = HEIGHT / 2;
  localparam int SW   = QW / 2;
  localparam int SH   = QH / 2;
  localparam int BINS = pqph_pkg::NUM_BINS;
  localparam longint unsigned BIN_MAX = (64'd1 << COUNT_BITS) - 1;

  logic [7:0]      threshold;
  bit              prev_row [WIDTH];
  bit              above_left;
  bit              left_bit;
  int unsigned     row_pos;
  int unsigned     col_pos;
  longint unsigned bin_model [BINS];
  logic [15:0]     pending_counts [$];

  // Band (0 or 1) of a two-wide window starting at a, or -1 if it straddles.
  function automatic int region_band(int unsigned a, int unsigned span);
    if (a / span >= 2 || (a + 1) / span != a / span) return -1;
    return int'(a / span);
  endfunction

  function automatic void bump_bin(int unsigned idx, int unsigned weight);
    longint unsigned sum;
    sum = bin_model[idx] + weight;
    bin_model[idx] = (sum > BIN_MAX) ? BIN_MAX : sum;
  endfunction

  always @(posedge clk) begin : track
    int              bx, by, sx, sy;
    int unsigned     c, q, x, y;
    bit              cur, above;
    logic [3:0]      pat;
    logic [8:0]      idx;
    longint unsigned count;
    logic [15:0]     want;
    if (!rst_n) begin
      threshold  = pqph_pkg::THRESH_RESET;
      prev_row   = '{default: 1'b0};
      above_left = 1'b0;
      left_bit   = 1'b0;
      row_pos    = 0;
      col_pos    = 0;
      bin_model  = '{default: 0};
      pending_counts.delete();
    end else begin
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (pending_counts.size() == 0) begin
          $error("bin_count: expected no beat, actual %0d", out_tdata);
          mismatches++;
        end else begin
          want = pending_counts.pop_front();
          reads_checked++;
          if (want == 16'hffff) saturated_reads++;
          if (out_tdata !== want) begin
            $error("bin_count: expected %0d, actual %0d", want, out_tdata);
            mismatches++;
          end
        end
      end

      if (cfg_we === 1'b1) threshold = cfg_wdata;

      if (in_tvalid === 1'b1 && in_tready === 1'b1) begin
        if (in_tuser == pqph_pkg::FUNC_PUSH) begin
          cur   = in_tdata[7:0] > threshold;
          c     = (col_pos >= WIDTH) ? 0 : col_pos;
          above = prev_row[c];
          // the window ends at this pixel; count it once a full 2x2 exists
          if (c >= 1 && row_pos >= 1) begin
            x   = c - 1;
            y   = row_pos - 1;
            pat = {above_left, above, left_bit, cur};
            bump_bin(pat, pqph_pkg::WEIGHT_WHOLE);
            bx = region_band(x, QW);
            by = region_band(y, QH);
            if (bx >= 0 && by >= 0) begin
              q = by * 2 + bx;
              bump_bin(pqph_pkg::QUAD_BASE + 16 * q + pat, pqph_pkg::WEIGHT_QUAD);
              sx = region_band(x - bx * QW, SW);
              sy = region_band(y - by * QH, SH);
              if (sx >= 0 && sy >= 0)
                bump_bin(pqph_pkg::SIXT_BASE + 16 * (4 * q + sy * 2 + sx) + pat,
                         pqph_pkg::WEIGHT_SIXT);
            end
          end
          above_left  = above;
          left_bit    = cur;
          prev_row[c] = cur;
          c++;
          if (c >= WIDTH) begin
            c = 0;
            row_pos++;
            if (row_pos >= HEIGHT) row_pos = 0;
          end
          col_pos = c;
        end else begin
          idx   = in_tdata[16:8];
          count = 0;
          // out-of-range index reads zero and clears nothing
          if (idx < pqph_pkg::NUM_BINS) begin
            count = bin_model[idx];
            if (in_tdata[17]) bin_model[idx] = 0;
          end
          pending_counts.push_back((count > 64'hffff) ? 16'hffff : count[15:0]);
        end
      end

      reads_outstanding = pending_counts.size();
    end
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pyramid quad pattern histogram.
// ----------------------------------------------------------------------------
// Drives pixel pushes and bin reads with random gaps on both channels. A short
// directed part hits field extremes and out-of-range reads, random segments
// mix pushes and reads over changing thresholds, and a final sweep reads back
// every bin. The checker instance predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH          = 48;
  localparam int HEIGHT         = 100;
  localparam int COUNT_BITS     = 16;
  localparam int RANDOM_ITEMS   = 700;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam longint unsigned CYCLE_LIMIT = 200_000;

  typedef enum int {
    IDLE_RANDOM,
    IDLE_NONE,
    IDLE_SPARSE
  } idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // pixel[7:0], bin_index[16:8], clear_after_read[17], zeros
  logic        in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // bin_count
  logic        cfg_we;
  logic [7:0]  cfg_wdata;  // binarize_threshold

  int          mismatches;
  int          reads_outstanding;
  int          reads_checked;
  int          saturated_reads;

  idle_mode_t  src_mode;
  idle_mode_t  sink_mode;
  int unsigned sink_hold;
  logic [7:0]  thresh_now;
  int unsigned pixels_sent;
  int unsigned reads_sent;

  pyramid_quad_pattern_histogram #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  pqph_bin_checker #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .reads_outstanding (reads_outstanding),
    .reads_checked     (reads_checked),
    .saturated_reads   (saturated_reads)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_gap(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 9) : 0;
      default:     return $urandom_range(0, 9);
    endcase
  endfunction

  // Favor values at the edges and right at the threshold.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return thresh_now;
      3:       return thresh_now + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] pick_index();
    if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, pqph_pkg::NUM_BINS - 1));
    return 9'($urandom_range(pqph_pkg::NUM_BINS, 511));
  endfunction

  task automatic send_beat(input logic func, input logic [7:0] pix,
                           input logic [8:0] idx, input logic clr);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {6'b0, clr, idx, pix};
    if (func == pqph_pkg::FUNC_READ) reads_sent++;
    else pixels_sent++;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic push_random_pixel();
    send_beat(pqph_pkg::FUNC_PUSH, pick_pixel(), 9'($urandom_range(0, 511)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic read_random_bin();
    send_beat(pqph_pkg::FUNC_READ, 8'($urandom_range(0, 255)), pick_index(),
              1'($urandom_range(0, 1)));
  endtask

  // Stop offering, drain every result, then let in-flight pushes retire.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (reads_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_idle();
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    thresh_now = value;
    @(negedge clk);
    cfg_we     <= 1'b0;
  endtask

  task automatic sweep_all_bins();
    for (int b = 0; b < pqph_pkg::NUM_BINS; b++)
      send_beat(pqph_pkg::FUNC_READ, 8'($urandom_range(0, 255)), 9'(b),
                1'($urandom_range(0, 1)));
  endtask

  // Result side: random stall per beat, plus one long hold-off on request.
  initial begin : sink
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = draw_gap(sink_mode);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d reads still outstanding", cycles,
             reads_outstanding);
    $display("[pyramid_quad_pattern_histogram] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned seg;
    int unsigned seg_len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = pqph_pkg::FUNC_PUSH;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    src_mode    = IDLE_RANDOM;
    sink_mode   = IDLE_RANDOM;
    sink_hold   = 0;
    thresh_now  = pqph_pkg::THRESH_RESET;
    pixels_sent = 0;
    reads_sent  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty bins after reset, both ends of the index range and beyond it
    send_beat(pqph_pkg::FUNC_READ, 8'h00, 9'd0, 1'b0);
    send_beat(pqph_pkg::FUNC_READ, 8'hff, pqph_pkg::NUM_BINS - 9'd1, 1'b1);
    send_beat(pqph_pkg::FUNC_READ, 8'h5a, pqph_pkg::NUM_BINS, 1'b0);
    send_beat(pqph_pkg::FUNC_READ, 8'ha5, 9'h1ff, 1'b1);
    // pixels at the extremes and around the reset threshold
    send_beat(pqph_pkg::FUNC_PUSH, 8'h00, 9'h1ff, 1'b1);
    send_beat(pqph_pkg::FUNC_PUSH, 8'hff, 9'h000, 1'b0);
    send_beat(pqph_pkg::FUNC_PUSH, pqph_pkg::THRESH_RESET, 9'h155, 1'b1);
    send_beat(pqph_pkg::FUNC_PUSH, pqph_pkg::THRESH_RESET + 8'd1, 9'h0aa, 1'b0);
    send_beat(pqph_pkg::FUNC_PUSH, pqph_pkg::THRESH_RESET - 8'd1, 9'h1ff, 1'b0);
    send_beat(pqph_pkg::FUNC_PUSH, 8'h80, 9'h000, 1'b1);
    send_beat(pqph_pkg::FUNC_READ, 8'h00, 9'd15, 1'b0);
    send_beat(pqph_pkg::FUNC_READ, 8'hff, pqph_pkg::QUAD_BASE, 1'b1);
    send_beat(pqph_pkg::FUNC_READ, 8'h33, pqph_pkg::SIXT_BASE - 9'd1, 1'b0);
    send_beat(pqph_pkg::FUNC_READ, 8'hcc, pqph_pkg::SIXT_BASE, 1'b1);
    send_beat(pqph_pkg::FUNC_READ, 8'h0f, 9'd256, 1'b0);

    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       write_threshold(8'h00);
        1:       write_threshold(8'hff);
        2:       write_threshold(8'($urandom_range(0, 255)));
        default: wait_idle();
      endcase
      src_mode  = idle_mode_t'($urandom_range(0, 2));
      sink_mode = idle_mode_t'($urandom_range(0, 2));
      if (seg == 2) begin
        // hold the result side off while reads keep coming, so the input stalls
        sink_hold = HOLD_CYCLES;
        src_mode  = IDLE_NONE;
        repeat (40) read_random_bin();
        sent += 40;
      end else begin
        seg_len = $urandom_range(40, 160);
        repeat (seg_len) begin
          if ($urandom_range(0, 3) == 0) read_random_bin();
          else push_random_pixel();
        end
        sent += seg_len;
      end
      seg++;
    end

    // read back every bin once the last pushes have landed
    wait_idle();
    src_mode  = IDLE_RANDOM;
    sink_mode = IDLE_RANDOM;
    sweep_all_bins();

    wait_idle();
    $display("covered %0d pixel beats and %0d bin reads in %0d random segments",
             pixels_sent, reads_sent, seg);
    $display("checked %0d read results, %0d of them at the saturated count",
             reads_checked, saturated_reads);
    if (mismatches == 0 && reads_outstanding == 0)
      $display("[pyramid_quad_pattern_histogram] OK");
    else
      $display("[pyramid_quad_pattern_histogram] ERROR");
    $finish;
  end

endmodule
